/* sv/fce_pkg.sv */
// shared types, constants and round functions of the block cipher core
// no dependencies; used by the interfaces, controller, datapath and top level
package fce_pkg;

  localparam int BLK_W      = 64;
  localparam int COL_W      = 16;
  localparam int RND_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int KEY_ROT    = 5;
  localparam int COL_ROT    = 16;

  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(10);
  localparam logic [RND_W-1:0] NOMIX_ROUND = RND_W'(9);
  localparam logic [RND_W-1:0] KROT_ROUND = RND_W'(2);

  localparam logic [BLK_W-1:0] RC_INIT = 64'h1248_2481_4812_8124;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_EVEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ODD  = 1'b1;

  localparam logic [3:0] SBOX [16] = '{
    4'd1, 4'd3, 4'd0, 4'd2, 4'd7, 4'd14, 4'd4, 4'd13,
    4'd9, 4'd10, 4'd12, 4'd6, 4'd15, 4'd5, 4'd8, 4'd11
  };

  // entry i selects the column bits that feed output bit 15-i
  localparam logic [COL_W-1:0] MIX_TAB [16] = '{
    16'h9189, 16'hC84C, 16'h6426, 16'h2312, 16'hC411, 16'h6288, 16'hB944, 16'h9833,
    16'h4C91, 16'h26C8, 16'h9B64, 16'h8923, 16'h1198, 16'h88C4, 16'h4462, 16'h3321
  };

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } fce_state_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             push;
    logic [RND_W-1:0] round;
  } fce_cmd_t;

  typedef struct packed {
    logic out_free;
  } fce_stat_t;

  function automatic logic [BLK_W-1:0] sub_word(input logic [BLK_W-1:0] x);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int n = 0; n < BLK_W / 4; n++) begin
      r[4*n +: 4] = SBOX[x[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic logic [COL_W-1:0] mix_col(input logic [COL_W-1:0] w);
    logic [COL_W-1:0] r;
    r = '0;
    for (int i = 0; i < COL_W; i++) begin
      r[COL_W-1-i] = ^(w & MIX_TAB[i]);
    end
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] mix_word(input logic [BLK_W-1:0] x);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int c = 0; c < BLK_W / COL_W; c++) begin
      r[COL_W*c +: COL_W] = mix_col(x[COL_W*c +: COL_W]);
    end
    return r;
  endfunction

  // nibble n (from the top) takes old nibble (n - 4*(n mod 4)) mod 16
  function automatic logic [BLK_W-1:0] shift_rows(input logic [BLK_W-1:0] x);
    logic [BLK_W-1:0] r;
    int src;
    r = '0;
    for (int n = 0; n < 16; n++) begin
      src = (n + 16 - 4 * (n & 3)) & 15;
      r[BLK_W-1-4*n -: 4] = x[BLK_W-1-4*src -: 4];
    end
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] rotl(input logic [BLK_W-1:0] x, input int s);
    return (x << s) | (x >> (BLK_W - s));
  endfunction

  // constant word takes part when (r3^r1)|(r2^r0)
  function automatic logic use_rc(input logic [RND_W-1:0] rd);
    return (rd[3] ^ rd[1]) | (rd[2] ^ rd[0]);
  endfunction

endpackage

/* sv/fce_pt_if.sv */
// plaintext stream channel: valid, ready and one 64-bit block per beat
// depends on fce_pkg
interface fce_pt_if;
  logic                         valid;
  logic                         ready;
  logic [fce_pkg::BLK_W-1:0]    plaintext;

  modport source(output valid, output plaintext, input ready);
  modport sink(input valid, input plaintext, output ready);
endinterface

/* sv/fce_ct_if.sv */
// ciphertext stream channel: valid, ready and one 64-bit block per beat
// depends on fce_pkg
interface fce_ct_if;
  logic                         valid;
  logic                         ready;
  logic [fce_pkg::BLK_W-1:0]    ciphertext;

  modport source(output valid, output ciphertext, input ready);
  modport sink(input valid, input ciphertext, output ready);
endinterface

/* sv/future_cipher_encrypt.sv */
// top level of the 64-bit block cipher core: round sequencer plus datapath
// depends on fce_pkg, fce_pt_if, fce_ct_if, fce_ctrl, fce_dpath
//
//  channel   dir   beat payload          handshake
//  in_ch     in    plaintext  [63:0]     valid / ready
//  out_ch    out   ciphertext [63:0]     valid / ready
//  cfg_*     in    key half   [63:0]     cfg_we, cfg_index (0 even, 1 odd)
//
// one round per cycle in the datapath (the last held while the output is full):
// a block runs rounds 0 to 10 from accept to result, one block at a time
// the next block is taken in the cycle the finished one moves to the output
// register; a stalled output holds the last round until the register frees
// reset clears both key halves to zero and empties the output register
module future_cipher_encrypt (
  input  logic                            clk,
  input  logic                            rst_n,
  fce_pt_if.sink                          in_ch,
  fce_ct_if.source                        out_ch,
  input  logic                            cfg_we,
  input  logic [fce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fce_pkg::BLK_W-1:0]       cfg_data
);

  fce_pkg::fce_cmd_t  cmd;
  fce_pkg::fce_stat_t stat;

  fce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fce_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .plaintext  (in_ch.plaintext),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .ciphertext (out_ch.ciphertext)
  );

endmodule

/* sv/fce_ctrl.sv */
// round sequencer: accepts blocks, steps the round counter, hands off results
// depends on fce_pkg
module fce_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fce_pkg::fce_stat_t  stat,
  output fce_pkg::fce_cmd_t   cmd
);

  fce_pkg::fce_state_t          state_r, state_nxt;
  logic [fce_pkg::RND_W-1:0]    round_r, round_nxt;
  logic                         last_rnd;
  logic                         take;

  assign last_rnd = (round_r == fce_pkg::LAST_ROUND);
  assign take     = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    unique case (state_r)
      fce_pkg::ST_IDLE: begin
        if (take) begin
          state_nxt = fce_pkg::ST_RUN;
          round_nxt = '0;
        end
      end
      fce_pkg::ST_RUN: begin
        if (!last_rnd) begin
          round_nxt = round_r + fce_pkg::RND_W'(1);
        end else if (stat.out_free) begin
          // result leaves; a waiting block can start right away
          if (take) begin
            round_nxt = '0;
          end else begin
            state_nxt = fce_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = fce_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    cmd.push  = 1'b0;
    cmd.round = round_r;
    unique case (state_r)
      fce_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      fce_pkg::ST_RUN: begin
        in_ready = last_rnd && stat.out_free;
        cmd.step = !last_rnd || stat.out_free;
        cmd.push = last_rnd && stat.out_free;
        cmd.load = last_rnd && stat.out_free && in_valid;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fce_pkg::ST_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  a_push_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (state_r == fce_pkg::ST_RUN) && last_rnd)
    else $error("result pushed before the last round");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == fce_pkg::ST_RUN) && (round_r == '0))
    else $error("accepted block did not start at round zero");

  a_round_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fce_pkg::ST_RUN) && !last_rnd
      |=> (state_r == fce_pkg::ST_RUN)
          && (round_r == fce_pkg::RND_W'($past(round_r) + fce_pkg::RND_W'(1))))
    else $error("round counter skipped or left the run early");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    round_r <= fce_pkg::LAST_ROUND)
    else $error("round counter past the last round");

endmodule

/* sv/fce_dpath.sv */
// round datapath: key registers, working keys, constant word, block state,
// one round per cycle (the last held while the output is full) and the output register; depends on fce_pkg
module fce_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fce_pkg::BLK_W-1:0]          cfg_data,
  input  logic [fce_pkg::BLK_W-1:0]          plaintext,
  input  fce_pkg::fce_cmd_t                  cmd,
  output fce_pkg::fce_stat_t                 stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fce_pkg::BLK_W-1:0]          ciphertext
);

  logic [fce_pkg::BLK_W-1:0] cfg_key_even_r, cfg_key_odd_r;
  logic [fce_pkg::BLK_W-1:0] key_even_r, key_even_nxt;
  logic [fce_pkg::BLK_W-1:0] key_odd_r, key_odd_nxt;
  logic [fce_pkg::BLK_W-1:0] rc_r, rc_nxt;
  logic [fce_pkg::BLK_W-1:0] state_r, state_nxt;
  logic [fce_pkg::BLK_W-1:0] ciphertext_r;
  logic                      out_valid_r, out_valid_nxt;

  logic [fce_pkg::BLK_W-1:0] key_use, rc_use, add_w, sub_w, mix_w, rnd_w;
  logic                      u;
  logic                      late;

  assign u    = fce_pkg::use_rc(cmd.round);
  assign late = (cmd.round >= fce_pkg::KROT_ROUND);

  // in rounds from 2 on that use it, the constant word turns by 16 bits, so each column
  // moves up one place; all four columns are worked at once
  always_comb begin
    key_use = cmd.round[0] ? key_odd_r : key_even_r;
    if (late) begin
      key_use = fce_pkg::rotl(key_use, fce_pkg::KEY_ROT);
    end
    rc_use = (late && u) ? fce_pkg::rotl(rc_r, fce_pkg::COL_ROT) : rc_r;
    add_w  = state_r ^ key_use ^ (u ? rc_use : '0);
    sub_w  = fce_pkg::sub_word(add_w);
    mix_w  = (cmd.round < fce_pkg::NOMIX_ROUND) ? fce_pkg::mix_word(sub_w) : sub_w;
    rnd_w  = (cmd.round < fce_pkg::LAST_ROUND) ? fce_pkg::shift_rows(mix_w) : add_w;
  end

  always_comb begin
    key_even_nxt = key_even_r;
    key_odd_nxt  = key_odd_r;
    rc_nxt       = rc_r;
    state_nxt    = state_r;
    if (cmd.load) begin
      key_even_nxt = cfg_key_even_r;
      key_odd_nxt  = cfg_key_odd_r;
      rc_nxt       = fce_pkg::RC_INIT;
      state_nxt    = plaintext;
    end else if (cmd.step) begin
      if (cmd.round[0]) begin
        key_odd_nxt = key_use;
      end else begin
        key_even_nxt = key_use;
      end
      rc_nxt    = rc_use;
      state_nxt = rnd_w;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_key_even_r <= '0;
      cfg_key_odd_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          fce_pkg::CFG_KEY_EVEN: cfg_key_even_r <= cfg_data;
          fce_pkg::CFG_KEY_ODD:  cfg_key_odd_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    key_even_r <= key_even_nxt;
    key_odd_r  <= key_odd_nxt;
    rc_r       <= rc_nxt;
    state_r    <= state_nxt;
    if (cmd.push) begin
      ciphertext_r <= rnd_w;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign ciphertext    = ciphertext_r;

endmodule
